FILE: src/lctp_pkg.sv
// ----------------------------------------------------------------------------
// Lighting command parser package
// Shared widths, the character class codes and the queue entry type used
// between the classifier, the queue and the parser core.
// ----------------------------------------------------------------------------
package lctp_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int OUT_WIDTH = 32;
  localparam int NUM_FIELDS = 5;
  localparam int FIELD_IDX_W = $clog2(NUM_FIELDS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    K_PAT,
    K_LOOP,
    K_CLR,
    K_TERM,
    K_SPACE,
    K_WS,
    K_PLUS,
    K_MINUS,
    K_DIGIT,
    K_OTHER
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] val;
    logic       flag;
  } item_t;

endpackage

FILE: src/lctp_front.sv
// ----------------------------------------------------------------------------
// Lighting command parser front end
// Accepts characters, tracks the header position and turns each character
// into a class code with its digit value before it enters the queue.
// ----------------------------------------------------------------------------
module lctp_front
  import lctp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       q_full,
  output logic       q_push,
  output item_t      q_item
);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  typedef enum logic [1:0] {
    POS_PAT,
    POS_LOOP,
    POS_CLR,
    POS_BODY
  } pos_t;

  pos_t pos_r;
  pos_t pos_nxt;
  logic [7:0] digit_off;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] t;
    logic       ok;
    begin
      t  = '0;
      ok = 1'b0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        t  = c - CH_ZERO;
        ok = 1'b1;
      end else if (c >= CH_UA && c <= CH_UF) begin
        t  = c - CH_UA + HEX_TEN;
        ok = 1'b1;
      end else if (c >= CH_LA && c <= CH_LF) begin
        t  = c - CH_LA + HEX_TEN;
        ok = 1'b1;
      end
      return {ok, t[3:0]};
    end
  endfunction

  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;
  assign digit_off = in_char_in - CH_ZERO;

  always_comb begin
    logic [4:0] hx;
    hx     = hex_decode(in_char_in);
    q_item = '{kind: K_OTHER, val: 4'd0, flag: 1'b0};
    if (in_char_in == CH_NUL) begin
      q_item.kind = K_TERM;
      q_item.flag = (pos_r == POS_BODY);
    end else begin
      unique case (pos_r)
        POS_PAT: begin
          q_item.kind = K_PAT;
          q_item.val  = hx[3:0];
          q_item.flag = hx[4];
        end
        POS_LOOP: begin
          q_item.kind = K_LOOP;
          q_item.flag = (in_char_in == CH_ONE);
        end
        POS_CLR: begin
          q_item.kind = K_CLR;
          q_item.flag = (in_char_in == CH_ONE);
        end
        POS_BODY: begin
          if (in_char_in == CH_SPACE) begin
            q_item.kind = K_SPACE;
          end else if (in_char_in >= CH_TAB && in_char_in <= CH_CR) begin
            q_item.kind = K_WS;
          end else if (in_char_in == CH_PLUS) begin
            q_item.kind = K_PLUS;
          end else if (in_char_in == CH_MINUS) begin
            q_item.kind = K_MINUS;
          end else if (in_char_in >= CH_ZERO && in_char_in <= CH_NINE) begin
            q_item.kind = K_DIGIT;
            q_item.val  = digit_off[3:0];
          end
        end
        default: q_item.kind = K_OTHER;
      endcase
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (q_push) begin
      if (in_char_in == CH_NUL) begin
        pos_nxt = POS_PAT;
      end else begin
        unique case (pos_r)
          POS_PAT:  pos_nxt = POS_LOOP;
          POS_LOOP: pos_nxt = POS_CLR;
          POS_CLR:  pos_nxt = POS_BODY;
          POS_BODY: pos_nxt = POS_BODY;
          default:  pos_nxt = POS_PAT;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_PAT;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

FILE: src/lctp_queue.sv
// ----------------------------------------------------------------------------
// Lighting command parser queue
// A short first-in first-out buffer of classified characters that lets the
// front end and the parser core stall independently.
// ----------------------------------------------------------------------------
module lctp_queue
  import lctp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  q_valid,
  output item_t q_item
);

  item_t                  mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [QUEUE_CNT_W-1:0] count_r;
  logic [QUEUE_PTR_W-1:0] wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_nxt;

  function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
    begin
      if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
        return '0;
      end
      return p + 1'b1;
    end
  endfunction

  assign full    = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("Queue count exceeds its depth.");

  a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("Queue popped while empty.");

endmodule

FILE: src/lctp_back.sv
// ----------------------------------------------------------------------------
// Lighting command parser core
// Consumes classified characters, keeps the header bits and the five number
// fields, and loads a record into the output register on each terminator.
// ----------------------------------------------------------------------------
module lctp_back
  import lctp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  item_t                q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           out_pattern_code,
  output logic                 out_pattern_valid,
  output logic                 out_loop_flag,
  output logic                 out_clear_flag,
  output logic [OUT_WIDTH-1:0] out_start_time,
  output logic [OUT_WIDTH-1:0] out_timeout_value,
  output logic [OUT_WIDTH-1:0] out_blink_rate,
  output logic [OUT_WIDTH-1:0] out_primary_color,
  output logic [OUT_WIDTH-1:0] out_secondary_color,
  output logic                 out_malformed
);

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_SIGN,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  logic [3:0]             pat_code_r, pat_code_nxt;
  logic                   pat_ok_r, pat_ok_nxt;
  logic                   loop_r, loop_nxt;
  logic                   clear_r, clear_nxt;
  logic [FIELD_IDX_W-1:0] idx_r, idx_nxt;
  logic [VALUE_WIDTH-1:0] store_r [NUM_FIELDS];
  logic [VALUE_WIDTH-1:0] store_nxt [NUM_FIELDS];
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  phase_t                 phase_r, phase_nxt;
  logic                   neg_r, neg_nxt;
  logic                   sat_r, sat_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [3:0]             out_pattern_code_r;
  logic                   out_pattern_valid_r;
  logic                   out_loop_flag_r;
  logic                   out_clear_flag_r;
  logic [OUT_WIDTH-1:0]   out_fields_r [NUM_FIELDS];
  logic                   out_malformed_r;

  logic [VALUE_WIDTH+3:0] acc_ext;
  logic [VALUE_WIDTH+3:0] acc_x10;
  logic                   ovf;
  logic [VALUE_WIDTH-1:0] fin;
  logic                   out_free;
  logic                   term_pop;
  logic [OUT_WIDTH-1:0]   rec_fields [NUM_FIELDS];
  logic                   body_open;

  function automatic logic [OUT_WIDTH-1:0] to_out(input logic [VALUE_WIDTH-1:0] v);
    logic [VALUE_WIDTH+OUT_WIDTH-1:0] ext;
    begin
      ext = {{OUT_WIDTH{1'b0}}, v};
      return ext[OUT_WIDTH-1:0];
    end
  endfunction

  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = q_valid && (q_item.kind != K_TERM || out_free);
  assign term_pop  = q_pop && (q_item.kind == K_TERM);
  assign body_open = (idx_r < FIELD_IDX_W'(NUM_FIELDS)) && (phase_r != PH_DONE);

  assign acc_ext = {4'b0000, acc_r};
  assign acc_x10 = (acc_ext << 3) + (acc_ext << 1) + {{VALUE_WIDTH{1'b0}}, q_item.val};
  assign ovf     = |acc_x10[VALUE_WIDTH+3:VALUE_WIDTH];
  assign fin     = (neg_r && !sat_r) ? (VALUE_WIDTH'(0) - acc_r) : acc_r;

  always_comb begin
    for (int k = 0; k < NUM_FIELDS; k++) begin
      if (idx_r == FIELD_IDX_W'(k)) begin
        rec_fields[k] = to_out(fin);
      end else begin
        rec_fields[k] = to_out(store_r[k]);
      end
    end
  end

  always_comb begin
    pat_code_nxt  = pat_code_r;
    pat_ok_nxt    = pat_ok_r;
    loop_nxt      = loop_r;
    clear_nxt     = clear_r;
    idx_nxt       = idx_r;
    store_nxt     = store_r;
    acc_nxt       = acc_r;
    phase_nxt     = phase_r;
    neg_nxt       = neg_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (term_pop) begin
      out_valid_nxt = 1'b1;
    end
    if (q_pop) begin
      unique case (q_item.kind)
        K_PAT: begin
          pat_code_nxt = q_item.val;
          pat_ok_nxt   = q_item.flag;
        end
        K_LOOP: loop_nxt = q_item.flag;
        K_CLR:  clear_nxt = q_item.flag;
        K_TERM: begin
          pat_code_nxt = '0;
          pat_ok_nxt   = 1'b0;
          loop_nxt     = 1'b0;
          clear_nxt    = 1'b0;
          idx_nxt      = '0;
          for (int k = 0; k < NUM_FIELDS; k++) begin
            store_nxt[k] = '0;
          end
          acc_nxt   = '0;
          phase_nxt = PH_LEAD;
          neg_nxt   = 1'b0;
          sat_nxt   = 1'b0;
        end
        K_SPACE: begin
          if (idx_r < FIELD_IDX_W'(NUM_FIELDS)) begin
            for (int k = 0; k < NUM_FIELDS; k++) begin
              if (idx_r == FIELD_IDX_W'(k)) begin
                store_nxt[k] = fin;
              end
            end
            idx_nxt = idx_r + 1'b1;
          end
          acc_nxt   = '0;
          phase_nxt = PH_LEAD;
          neg_nxt   = 1'b0;
          sat_nxt   = 1'b0;
        end
        default: begin
          if (body_open) begin
            unique case (q_item.kind)
              K_WS: begin
                if (phase_r != PH_LEAD) begin
                  phase_nxt = PH_DONE;
                end
              end
              K_PLUS, K_MINUS: begin
                if (phase_r == PH_LEAD) begin
                  neg_nxt   = (q_item.kind == K_MINUS);
                  phase_nxt = PH_SIGN;
                end else begin
                  phase_nxt = PH_DONE;
                end
              end
              K_DIGIT: begin
                phase_nxt = PH_DIGITS;
                if (sat_r || ovf) begin
                  sat_nxt = 1'b1;
                  acc_nxt = '1;
                end else begin
                  acc_nxt = acc_x10[VALUE_WIDTH-1:0];
                end
              end
              default: phase_nxt = PH_DONE;
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_code_r  <= '0;
      pat_ok_r    <= 1'b0;
      loop_r      <= 1'b0;
      clear_r     <= 1'b0;
      idx_r       <= '0;
      for (int k = 0; k < NUM_FIELDS; k++) begin
        store_r[k] <= '0;
      end
      acc_r       <= '0;
      phase_r     <= PH_LEAD;
      neg_r       <= 1'b0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pat_code_r  <= pat_code_nxt;
      pat_ok_r    <= pat_ok_nxt;
      loop_r      <= loop_nxt;
      clear_r     <= clear_nxt;
      idx_r       <= idx_nxt;
      store_r     <= store_nxt;
      acc_r       <= acc_nxt;
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (term_pop) begin
      out_pattern_code_r  <= pat_code_r;
      out_pattern_valid_r <= pat_ok_r;
      out_loop_flag_r     <= loop_r;
      out_clear_flag_r    <= clear_r;
      out_fields_r        <= rec_fields;
      out_malformed_r     <= !q_item.flag || (idx_r < FIELD_IDX_W'(NUM_FIELDS - 1));
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pattern_code    = out_pattern_code_r;
  assign out_pattern_valid   = out_pattern_valid_r;
  assign out_loop_flag       = out_loop_flag_r;
  assign out_clear_flag      = out_clear_flag_r;
  assign out_start_time      = out_fields_r[0];
  assign out_timeout_value   = out_fields_r[1];
  assign out_blink_rate      = out_fields_r[2];
  assign out_primary_color   = out_fields_r[3];
  assign out_secondary_color = out_fields_r[4];
  assign out_malformed       = out_malformed_r;

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= FIELD_IDX_W'(NUM_FIELDS))
    else $error("Field index ran past the last field.");

  a_clear_after_record: assert property (@(posedge clk) disable iff (!rst_n)
    term_pop |=> (idx_r == '0) && (phase_r == PH_LEAD) && (acc_r == '0))
    else $error("Parser state not cleared after a record.");

  a_sat_holds_max: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |-> (&acc_r))
    else $error("Saturated field does not hold the maximum value.");

  a_lead_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LEAD) |-> (!sat_r && !neg_r && (acc_r == '0)))
    else $error("Leading phase entered with stale token state.");

endmodule

FILE: src/lighting_command_text_parser_unit.sv
// ----------------------------------------------------------------------------
// Lighting command text parser
// The block takes a lighting command one ASCII character per item on the
// input channel (in_valid, in_stall, in_char_in). A zero byte ends the
// command and produces one record on the output channel (out_valid,
// out_stall and the record fields); every other character produces none.
// The first three characters are the pattern digit, the loop flag and the
// clear flag; the rest splits on spaces into five decimal fields.
// One character is accepted every clock cycle while in_stall is low. The
// front end classifies a character on the edge that accepts it into a
// two-entry queue. The parser core consumes one queue entry per cycle, but
// not a terminator while a record waits; that pop loads the output register.
// While a record waits under out_stall, the core keeps parsing the next
// command; a later terminator waits in the queue, and in_stall rises once
// the queue holds two entries.
// A synchronous reset on rst_n empties the queue, clears the output valid
// and returns the parser to the start of a header.
// ----------------------------------------------------------------------------
module lighting_command_text_parser_unit
  import lctp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_char_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           out_pattern_code,
  output logic                 out_pattern_valid,
  output logic                 out_loop_flag,
  output logic                 out_clear_flag,
  output logic [OUT_WIDTH-1:0] out_start_time,
  output logic [OUT_WIDTH-1:0] out_timeout_value,
  output logic [OUT_WIDTH-1:0] out_blink_rate,
  output logic [OUT_WIDTH-1:0] out_primary_color,
  output logic [OUT_WIDTH-1:0] out_secondary_color,
  output logic                 out_malformed
);

  logic  q_full;
  logic  q_push;
  item_t push_item;
  logic  q_pop;
  logic  q_valid;
  item_t q_item;

  lctp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char_in (in_char_in),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (push_item)
  );

  lctp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  lctp_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_pattern_code    (out_pattern_code),
    .out_pattern_valid   (out_pattern_valid),
    .out_loop_flag       (out_loop_flag),
    .out_clear_flag      (out_clear_flag),
    .out_start_time      (out_start_time),
    .out_timeout_value   (out_timeout_value),
    .out_blink_rate      (out_blink_rate),
    .out_primary_color   (out_primary_color),
    .out_secondary_color (out_secondary_color),
    .out_malformed       (out_malformed)
  );

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// Lighting command text parser testbench
// Feeds command characters to lighting_command_text_parser_unit as a stream
// of complete commands, directed ones first and then random ones. Most of
// the random commands are well formed with random content, and the rest are
// short, truncated, over-long or noisy. A parser written here predicts the
// record of each terminator as it is accepted, and every record that leaves
// the block is checked field by field against the oldest prediction. The
// sender works in bursts with random gaps, and the receiver stalls in
// changing patterns.
// ----------------------------------------------------------------------------
module testbench;
  import lctp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;
  localparam int ITEM_TARGET = 1850;
  localparam logic [63:0] VALUE_MAX = {64{1'b1}} >> (64 - VALUE_WIDTH);

  localparam logic [7:0] CH_TERM = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_PLUS = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_ZERO = "0";
  localparam logic [7:0] CH_ONE = "1";
  localparam logic [7:0] CH_NINE = "9";
  localparam logic [7:0] CH_UPPER_A = "A";
  localparam logic [7:0] CH_UPPER_F = "F";
  localparam logic [7:0] CH_LOWER_A = "a";
  localparam logic [7:0] CH_LOWER_F = "f";
  localparam logic [7:0] CH_TOP = 8'hFF;

  typedef enum int {POS_PATTERN, POS_LOOP, POS_CLEAR, POS_BODY} command_pos_t;
  typedef enum int {PHASE_LEAD, PHASE_SIGN, PHASE_DIGITS, PHASE_DONE} number_phase_t;
  typedef enum int {FLOW_OPEN, FLOW_RANDOM, FLOW_HEAVY} flow_mode_t;

  typedef struct {
    logic [3:0]           pattern_code;
    logic                 pattern_valid;
    logic                 loop_flag;
    logic                 clear_flag;
    logic [OUT_WIDTH-1:0] number [NUM_FIELDS];
    logic                 malformed;
  } command_record_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_char_in = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [3:0]           out_pattern_code;
  logic                 out_pattern_valid;
  logic                 out_loop_flag;
  logic                 out_clear_flag;
  logic [OUT_WIDTH-1:0] out_start_time;
  logic [OUT_WIDTH-1:0] out_timeout_value;
  logic [OUT_WIDTH-1:0] out_blink_rate;
  logic [OUT_WIDTH-1:0] out_primary_color;
  logic [OUT_WIDTH-1:0] out_secondary_color;
  logic                 out_malformed;

  logic [7:0]      command_chars [$];
  command_record_t command_records [$];
  int              mismatch_count = 0;
  int              idle_cycles = 0;
  logic            in_taken = 1'b0;
  int              burst_left = 0;
  int              gap_left = 0;
  flow_mode_t      flow_mode = FLOW_OPEN;
  int              flow_left = 0;

  command_pos_t    cmd_pos = POS_PATTERN;
  int unsigned     field_num = 0;
  logic [63:0]     field_value [NUM_FIELDS] = '{default: '0};
  logic [4:0]      pattern_bits = '0;
  logic            loop_bit = 1'b0;
  logic            clear_bit = 1'b0;
  number_phase_t   num_phase = PHASE_LEAD;
  logic            num_negative = 1'b0;
  logic            num_saturated = 1'b0;

  lighting_command_text_parser_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_char_in          (in_char_in),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_pattern_code    (out_pattern_code),
    .out_pattern_valid   (out_pattern_valid),
    .out_loop_flag       (out_loop_flag),
    .out_clear_flag      (out_clear_flag),
    .out_start_time      (out_start_time),
    .out_timeout_value   (out_timeout_value),
    .out_blink_rate      (out_blink_rate),
    .out_primary_color   (out_primary_color),
    .out_secondary_color (out_secondary_color),
    .out_malformed       (out_malformed)
  );

  always #5 clk = ~clk;

  function void add_char(logic [7:0] c);
    command_chars.insert(command_chars.size(), c);
  endfunction

  function automatic logic [4:0] hex_digit(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return {1'b1, 4'(c - CH_ZERO)};
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return {1'b1, 4'(c - CH_UPPER_A + 8'd10)};
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) return {1'b1, 4'(c - CH_LOWER_A + 8'd10)};
    return 5'd0;
  endfunction

  function void close_field();
    if (field_num < NUM_FIELDS && num_negative && !num_saturated)
      field_value[field_num] = (64'd0 - field_value[field_num]) & VALUE_MAX;
    num_phase = PHASE_LEAD;
    num_negative = 1'b0;
    num_saturated = 1'b0;
  endfunction

  function void clear_command();
    cmd_pos = POS_PATTERN;
    field_num = 0;
    foreach (field_value[k]) field_value[k] = '0;
    pattern_bits = '0;
    loop_bit = 1'b0;
    clear_bit = 1'b0;
    num_phase = PHASE_LEAD;
    num_negative = 1'b0;
    num_saturated = 1'b0;
  endfunction

  function void parse_body_char(logic [7:0] c);
    logic [63:0] digit;
    if (c == CH_SPACE) begin
      close_field();
      if (field_num < NUM_FIELDS) field_num++;
      return;
    end
    if (field_num >= NUM_FIELDS || num_phase == PHASE_DONE) return;
    if (num_phase == PHASE_LEAD && c >= CH_TAB && c <= CH_CR) return;
    if (num_phase == PHASE_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
      num_negative = (c == CH_MINUS);
      num_phase = PHASE_SIGN;
      return;
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      digit = 64'(c) - 64'(CH_ZERO);
      num_phase = PHASE_DIGITS;
      if (num_saturated || field_value[field_num] > (VALUE_MAX - digit) / 10) begin
        num_saturated = 1'b1;
        field_value[field_num] = VALUE_MAX;
      end else begin
        field_value[field_num] = field_value[field_num] * 10 + digit;
      end
      return;
    end
    num_phase = PHASE_DONE;
  endfunction

  function void parse_command_char(logic [7:0] c);
    command_record_t rec;
    if (c != CH_TERM) begin
      case (cmd_pos)
        POS_PATTERN: begin
          pattern_bits = hex_digit(c);
          cmd_pos = POS_LOOP;
        end
        POS_LOOP: begin
          loop_bit = (c == CH_ONE);
          cmd_pos = POS_CLEAR;
        end
        POS_CLEAR: begin
          clear_bit = (c == CH_ONE);
          cmd_pos = POS_BODY;
        end
        default: parse_body_char(c);
      endcase
      return;
    end
    if (cmd_pos == POS_BODY) close_field();
    rec.pattern_code = pattern_bits[3:0];
    rec.pattern_valid = pattern_bits[4];
    rec.loop_flag = loop_bit;
    rec.clear_flag = clear_bit;
    foreach (rec.number[k]) rec.number[k] = field_value[k][OUT_WIDTH-1:0];
    rec.malformed = (cmd_pos != POS_BODY || field_num < NUM_FIELDS - 1);
    command_records.insert(command_records.size(), rec);
    clear_command();
  endfunction

  function void compare_field(string name, logic [OUT_WIDTH-1:0] got,
                              logic [OUT_WIDTH-1:0] want);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t %s: expected %0d (0x%0h), got %0d (0x%0h)",
                 $realtime, name, want, want, got, got);
    end
  endfunction

  function automatic logic [7:0] any_char();
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  task automatic add_number_field();
    int unsigned pick;
    int unsigned n_digits;
    logic [7:0]  junk;
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 2)) add_char(8'($urandom_range(CH_TAB, CH_CR)));
    pick = $urandom_range(0, 9);
    if (pick < 2) add_char(CH_MINUS);
    else if (pick == 2) add_char(CH_PLUS);
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      push_text("4294967295");
    end else if (pick == 1) begin
      push_text("4294967296");
    end else begin
      n_digits = (pick < 4) ? 0 : (pick < 7) ? $urandom_range(10, 20) : $urandom_range(1, 9);
      repeat (n_digits) add_char(8'(CH_ZERO + $urandom_range(0, 9)));
    end
    if ($urandom_range(0, 9) == 0) begin
      junk = any_char();
      add_char((junk == CH_SPACE) ? CH_TOP : junk);
    end
  endtask

  task automatic add_random_command();
    string       hex_chars;
    int unsigned pick;
    int unsigned n_fields;
    hex_chars = "0123456789ABCDEFabcdef";
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(0, 2)) add_char(any_char());
      add_char(CH_TERM);
      return;
    end
    if ($urandom_range(0, 3) != 0)
      add_char(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
    else
      add_char(any_char());
    repeat (2) begin
      if ($urandom_range(0, 4) != 0)
        add_char($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
      else
        add_char(any_char());
    end
    pick = $urandom_range(0, 9);
    n_fields = (pick < 6) ? 5 : (pick < 8) ? $urandom_range(6, 8) : $urandom_range(0, 4);
    for (int k = 0; k < n_fields; k++) begin
      if (k != 0) add_char(CH_SPACE);
      add_number_field();
      if ($urandom_range(0, 49) == 0) add_char(any_char());
    end
    add_char(CH_TERM);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (command_chars.size() != 0) begin
        in_valid <= 1'b1;
        in_char_in <= command_chars.pop_front();
        if (burst_left <= 1) begin
          if ($urandom_range(0, 3) == 0) begin
            burst_left <= $urandom_range(100, 300);
            gap_left <= 0;
          end else begin
            burst_left <= $urandom_range(1, 16);
            gap_left <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (flow_left == 0) begin
      flow_mode <= flow_mode_t'($urandom_range(0, 2));
      flow_left <= $urandom_range(20, 300);
    end else begin
      flow_left <= flow_left - 1;
    end
    case (flow_mode)
      FLOW_OPEN: out_stall <= 1'b0;
      FLOW_RANDOM: out_stall <= ($urandom_range(0, 1) == 1);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) parse_command_char(in_char_in);
    end
  end

  always @(posedge clk) begin : record_check
    command_record_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (command_records.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t record with no expectation: start_time 0x%0h malformed %0b",
                   $realtime, out_start_time, out_malformed);
      end else begin
        want = command_records.pop_front();
        compare_field("pattern_code", out_pattern_code, want.pattern_code);
        compare_field("pattern_valid", out_pattern_valid, want.pattern_valid);
        compare_field("loop_flag", out_loop_flag, want.loop_flag);
        compare_field("clear_flag", out_clear_flag, want.clear_flag);
        compare_field("start_time", out_start_time, want.number[0]);
        compare_field("timeout_value", out_timeout_value, want.number[1]);
        compare_field("blink_rate", out_blink_rate, want.number[2]);
        compare_field("primary_color", out_primary_color, want.number[3]);
        compare_field("secondary_color", out_secondary_color, want.number[4]);
        compare_field("malformed", out_malformed, want.malformed);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("lighting_command_text_parser_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    add_char(CH_TERM);
    push_text("g1");
    add_char(CH_TERM);
    push_text("F11-4294967296 +7 \t\r9x  4294967295");
    add_char(CH_TERM);
    push_text("a0");
    add_char(CH_TOP);
    push_text("-1 1 2 3 4 5");
    add_char(CH_TERM);
    push_text("911- +");
    add_char(CH_TERM);
    while (command_chars.size() < ITEM_TARGET) add_random_command();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (command_chars.size() != 0 || in_valid || command_records.size() != 0)
      @(negedge clk);
    repeat (10) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("lighting_command_text_parser_unit: match");
    end else begin
      $display("lighting_command_text_parser_unit: mismatch");
    end
    $finish;
  end

endmodule
